[sv/sgr_pkg.sv]
`default_nettype none
package sgr_pkg;

  localparam int CHAR_W = 21;
  localparam int WORD_W = 16;
  localparam int ACC_W  = 10;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + WORD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEF_ATTR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_BG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_BG  = 3'd4;

  localparam logic [WORD_W-1:0] DEF_ATTR_RST  = 16'd7;
  localparam logic [WORD_W-1:0] DEF_COLOR_RST = 16'd7;
  localparam logic [WORD_W-1:0] DEF_BG_RST    = 16'd0;
  localparam logic [WORD_W-1:0] INT_MASK_RST  = 16'd136;
  localparam logic [WORD_W-1:0] WHITE_BG_RST  = 16'd112;

  localparam logic [CHAR_W-1:0] CH_ESC   = 21'd27;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 21'd91;
  localparam logic [CHAR_W-1:0] CH_M     = 21'd109;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 21'd59;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 21'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 21'd57;

  localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;

  localparam logic [ACC_W-1:0] SGR_RESET     = 10'd0;
  localparam logic [ACC_W-1:0] SGR_BOLD      = 10'd1;
  localparam logic [ACC_W-1:0] SGR_BLINK     = 10'd5;
  localparam logic [ACC_W-1:0] SGR_NORMAL    = 10'd22;
  localparam logic [ACC_W-1:0] SGR_FG_LO     = 10'd30;
  localparam logic [ACC_W-1:0] SGR_FG_HI     = 10'd37;
  localparam logic [ACC_W-1:0] SGR_BRIGHT_LO = 10'd90;
  localparam logic [ACC_W-1:0] SGR_BRIGHT_HI = 10'd97;
  localparam logic [ACC_W-1:0] SGR_BG_RED    = 10'd101;

  localparam logic [WORD_W-1:0] FG_INTENSITY = 16'h0008;
  localparam logic [WORD_W-1:0] BG_RED       = 16'h0040;

  // ansi color index to console bits: red 4, green 2, blue 1
  function automatic logic [WORD_W-1:0] fg_of(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    w = '0;
    w[2] = idx[0];
    w[1] = idx[1];
    w[0] = idx[2];
    return w;
  endfunction

endpackage
`default_nettype wire

[sv/ansi_sgr_to_console_attribute.sv]
`default_nettype none
// channel | ports                          | payload
// in      | in_tvalid/in_tready            | tdata: char_code; tlast: last_of_text
// out     | out_tvalid/out_tready          | tdata: out_char, attribute_word;
//         |                                | tuser: is_attribute
// cfg     | cfg_valid/cfg_ready            | cfg_index, cfg_data (16 bit register)
//
// one item per cycle while the result is not stalled: an input register feeds a single
// pass of decode into the parser state and the result register, so throughput is one
// character per clock; an accepted item passes the input register, then the result register
// rst_n (synchronous) returns the parser to text phase and loads register defaults
// a stalled result holds; the input register still takes one more item meanwhile
module ansi_sgr_to_console_attribute
  import sgr_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire [IN_TDATA_W-1:0]    in_tdata,   // [20:0] char_code, rest zero
  input  wire                     in_tlast,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // [20:0] out_char, [36:21] attribute_word
  output logic                    out_tuser,  // [0] is_attribute
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [CFG_IDX_W-1:0]     cfg_index,
  input  wire [WORD_W-1:0]        cfg_data
);

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_SEQ  = 2'd2;

  logic [WORD_W-1:0] def_attr_r, def_color_r, def_bg_r, int_mask_r, white_bg_r;

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0] seq_bg_r, seq_bg_nxt;
  logic [WORD_W-1:0] cur_int_r, cur_int_nxt;
  logic [WORD_W-1:0] cur_col_r, cur_col_nxt;

  logic              out_vld_r;
  logic              out_attr_flag_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [WORD_W-1:0] out_word_r;

  logic              adv;
  logic              emit, emit_attr;
  logic [ACC_W+3:0]  acc_wide;
  logic [WORD_W-1:0] bright;
  logic [ACC_W-1:0]  fg_off;
  logic              is_digit, is_apply;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = !in_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_attr_flag_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W-WORD_W){1'b0}}, out_word_r, out_char_r};

  assign bright   = (def_attr_r ^ FG_INTENSITY) & int_mask_r;
  assign is_digit = (in_char_r >= CH_ZERO) && (in_char_r <= CH_NINE);
  assign is_apply = (in_char_r == CH_M) || (in_char_r == CH_SEMI);
  assign acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                    {10'd0, in_char_r[3:0]};
  assign fg_off   = (acc_r >= SGR_BRIGHT_LO) ? acc_r - SGR_BRIGHT_LO : acc_r - SGR_FG_LO;

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    seq_bg_nxt  = seq_bg_r;
    cur_int_nxt = cur_int_r;
    cur_col_nxt = cur_col_r;
    emit        = 1'b0;
    emit_attr   = 1'b0;
    case (phase_r)
      PH_ESC: begin
        emit      = 1'b1;
        emit_attr = 1'b1;
        phase_nxt = PH_TEXT;
        if (in_char_r == CH_LBRK) begin
          acc_nxt    = '0;
          seq_bg_nxt = def_bg_r;
          if (!in_last_r) begin
            emit      = 1'b0;
            emit_attr = 1'b0;
            phase_nxt = PH_SEQ;
          end
        end
      end
      PH_SEQ: begin
        if (is_digit) begin
          acc_nxt = (acc_wide > {4'd0, ACC_MAX}) ? ACC_MAX : acc_wide[ACC_W-1:0];
        end else if (is_apply) begin
          acc_nxt = '0;
          if (acc_r == SGR_RESET) begin
            cur_int_nxt = def_attr_r;
            cur_col_nxt = def_color_r | seq_bg_r;
          end else if (acc_r == SGR_BOLD || acc_r == SGR_BLINK) begin
            cur_int_nxt = bright;
          end else if (acc_r == SGR_NORMAL) begin
            cur_int_nxt = def_attr_r;
          end else if (acc_r == SGR_BG_RED) begin
            seq_bg_nxt = BG_RED;
          end else if ((acc_r >= SGR_FG_LO && acc_r <= SGR_FG_HI) ||
                       (acc_r >= SGR_BRIGHT_LO && acc_r <= SGR_BRIGHT_HI)) begin
            if (fg_off[2:0] == 3'd0) begin
              cur_col_nxt = white_bg_r;
            end else begin
              cur_col_nxt = fg_of(fg_off[2:0]) | seq_bg_r;
            end
            if (acc_r >= SGR_BRIGHT_LO) begin
              cur_int_nxt = bright;
            end
          end
        end
        if ((is_apply && in_char_r == CH_M) || in_last_r) begin
          emit      = 1'b1;
          emit_attr = 1'b1;
          phase_nxt = PH_TEXT;
        end
      end
      default: begin
        if (in_char_r == CH_ESC) begin
          if (in_last_r) begin
            emit      = 1'b1;
            emit_attr = 1'b1;
            phase_nxt = PH_TEXT;
          end else begin
            phase_nxt = PH_ESC;
          end
        end else begin
          emit      = 1'b1;
          phase_nxt = PH_TEXT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_attr_r  <= DEF_ATTR_RST;
      def_color_r <= DEF_COLOR_RST;
      def_bg_r    <= DEF_BG_RST;
      int_mask_r  <= INT_MASK_RST;
      white_bg_r  <= WHITE_BG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEF_ATTR:  def_attr_r  <= cfg_data;
        REG_DEF_COLOR: def_color_r <= cfg_data;
        REG_DEF_BG:    def_bg_r    <= cfg_data;
        REG_INT_MASK:  int_mask_r  <= cfg_data;
        REG_WHITE_BG:  white_bg_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[CHAR_W-1:0];
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TEXT;
      acc_r     <= '0;
      seq_bg_r  <= '0;
      cur_int_r <= '0;
      cur_col_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= in_vld_r && emit;
      end
      if (in_vld_r && adv) begin
        phase_r   <= phase_nxt;
        acc_r     <= acc_nxt;
        seq_bg_r  <= seq_bg_nxt;
        cur_int_r <= cur_int_nxt;
        cur_col_r <= cur_col_nxt;
      end
    end
    if (in_vld_r && adv && emit) begin
      out_attr_flag_r <= emit_attr;
      out_char_r      <= emit_attr ? '0 : in_char_r;
      out_word_r      <= emit_attr ? (cur_int_nxt | cur_col_nxt) : '0;
    end
  end

  // attribute results carry no character, text results carry no attribute
  a_attr_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_attr_flag_r |-> out_char_r == '0)
    else $error("attribute result with nonzero character");

  a_text_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_attr_flag_r |-> out_word_r == '0)
    else $error("text result with nonzero attribute");

  // the unused phase code is never entered
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("parser reached unused phase");

  // an item held in the input register while the result stalls is not dropped
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_char_r) && $stable(phase_r))
    else $error("stalled item lost");

  // any result leaves the parser in text phase
  a_emit_text: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && adv && emit |=> phase_r == PH_TEXT)
    else $error("result emitted with escape still open");

endmodule
`default_nettype wire
